// File: hw/rtl/hhbp_pkg.sv
// Shared types, constants and name tables for the HTTP header block parser.
`default_nettype none
package hhbp_pkg;

	localparam int unsigned LineLenW = 16;
	localparam int unsigned LineCntW = 17;

	localparam logic [LineLenW-1:0] LINE_LIMIT_RESET = 16'd16384;
	localparam logic [LineCntW-1:0] LINE_COUNT_MAX   = 17'h1FFFF;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic [3:0] CONN_NAME_LEN = 4'd10;
	localparam logic [3:0] CLEN_NAME_LEN = 4'd14;

	// Result status codes
	typedef enum logic [2:0] {
		ST_BUSY    = 3'd0,
		ST_DONE    = 3'd1,
		ST_BAD     = 3'd2,
		ST_CLOSED  = 3'd3,
		ST_IGNORED = 3'd4
	} status_t;

	// Position within a header line
	typedef enum logic [2:0] {
		PH_NAME,
		PH_NAME_CR,
		PH_SP1,
		PH_VAL,
		PH_VAL_CR,
		PH_SP2,
		PH_SP2_CR
	} phase_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
		logic       first;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic       conn_value_valid;
		logic [7:0] conn_value_byte;
		logic       conn_seen;
		logic       clen_seen;
	} out_item_t;

	// Lowercase letters of "connection"
	function automatic logic [7:0] conn_char(input logic [3:0] idx);
		logic [7:0] c;
		begin
			case (idx)
				4'd0: c = "c";
				4'd1: c = "o";
				4'd2: c = "n";
				4'd3: c = "n";
				4'd4: c = "e";
				4'd5: c = "c";
				4'd6: c = "t";
				4'd7: c = "i";
				4'd8: c = "o";
				4'd9: c = "n";
				default: c = 8'h00;
			endcase
			return c;
		end
	endfunction

	// Lowercase letters of "content-length"
	function automatic logic [7:0] clen_char(input logic [3:0] idx);
		logic [7:0] c;
		begin
			case (idx)
				4'd0:  c = "c";
				4'd1:  c = "o";
				4'd2:  c = "n";
				4'd3:  c = "t";
				4'd4:  c = "e";
				4'd5:  c = "n";
				4'd6:  c = "t";
				4'd7:  c = "-";
				4'd8:  c = "l";
				4'd9:  c = "e";
				4'd10: c = "n";
				4'd11: c = "g";
				4'd12: c = "t";
				4'd13: c = "h";
				default: c = 8'h00;
			endcase
			return c;
		end
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/http_header_block_parser.sv
// HTTP/1.1 header block parser: one byte per transaction, one result per byte.
// Each byte waits in the input register and its result in the output register, where
// a stalled result is held. Throughput: one transaction per cycle while the output
// accepts; the parser state updates as the input register drains into the output
// register, so back-to-back bytes see fresh state.
// Reset: arst_n clears all parser state and sets the line limit max_len_q to 16384.
`default_nettype none
module http_header_block_parser (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  hhbp_pkg::in_item_t      in_data,
	output logic                    out_valid,
	input  wire                     out_ready,
	output hhbp_pkg::out_item_t     out_data,
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire [15:0]              cfg_data
);

	// Input stage
	logic               vld_s1;
	hhbp_pkg::in_item_t item_s1;
	logic               fire_s1;

	// Output register
	logic                out_vld_q;
	hhbp_pkg::out_item_t out_q;

	// Configuration
	logic [hhbp_pkg::LineLenW-1:0] max_len_q;

	// Parser state
	hhbp_pkg::phase_t              phase_q, n_phase;
	logic [hhbp_pkg::LineCntW-1:0] line_q, n_line;
	logic [3:0]                    npos_q, n_npos;
	logic                          mconn_q, n_mconn;
	logic                          mclen_q, n_mclen;
	logic                          cflag_q, n_cflag;
	logic                          lflag_q, n_lflag;
	logic [1:0]                    vlen_q, n_vlen;
	logic                          vzero_q, n_vzero;
	logic                          fin_q, n_fin;
	logic                          hold_v_q, n_hold_v;
	logic [7:0]                    hold_b_q, n_hold_b;

	hhbp_pkg::out_item_t res;

	assign cfg_ready = 1'b1;
	assign fire_s1   = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready  = !vld_s1 || fire_s1;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	// Hold the line limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= hhbp_pkg::LINE_LIMIT_RESET;
		end else if (cfg_valid) begin
			max_len_q <= cfg_data;
		end
	end

	// Capture input transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (fire_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Compute next parser state and the result for the byte in the input stage
	always_comb begin
		hhbp_pkg::status_t st;
		logic       sv;
		logic [7:0] sb;
		logic       bad;
		logic       done;
		logic       do_name;
		logic       do_val;
		logic       do_end;
		logic       is_c;
		logic       is_l;
		logic [7:0] b;
		logic [7:0] lcb;

		n_phase  = phase_q;
		n_line   = line_q;
		n_npos   = npos_q;
		n_mconn  = mconn_q;
		n_mclen  = mclen_q;
		n_cflag  = cflag_q;
		n_lflag  = lflag_q;
		n_vlen   = vlen_q;
		n_vzero  = vzero_q;
		n_fin    = fin_q;
		n_hold_v = hold_v_q;
		n_hold_b = hold_b_q;
		st       = hhbp_pkg::ST_BUSY;
		sv       = 1'b0;
		sb       = 8'h00;
		bad      = 1'b0;
		done     = 1'b0;
		do_name  = 1'b0;
		do_val   = 1'b0;
		do_end   = 1'b0;
		is_c     = 1'b0;
		is_l     = 1'b0;
		b        = item_s1.data_byte;
		lcb      = ((b >= "A") && (b <= "Z")) ? (b + 8'd32) : b;

		// Start a new header block
		if (item_s1.first) begin
			n_phase  = hhbp_pkg::PH_NAME;
			n_line   = '0;
			n_npos   = '0;
			n_mconn  = 1'b1;
			n_mclen  = 1'b1;
			n_vlen   = '0;
			n_vzero  = 1'b0;
			n_cflag  = 1'b0;
			n_lflag  = 1'b0;
			n_fin    = 1'b0;
			n_hold_v = 1'b0;
			n_hold_b = 8'h00;
		end

		if (n_fin) begin
			st = hhbp_pkg::ST_IGNORED;
		end else begin
			// Release a trailing value byte
			if (n_hold_v) begin
				sv       = 1'b1;
				sb       = n_hold_b;
				n_hold_v = 1'b0;
			end
			if (item_s1.cmd) begin
				n_fin    = 1'b1;
				n_hold_v = 1'b0;
				st       = hhbp_pkg::ST_CLOSED;
			end else begin
				if (n_line != hhbp_pkg::LINE_COUNT_MAX) begin
					n_line = n_line + hhbp_pkg::LineCntW'(1);
				end
				if (n_line > {1'b0, max_len_q}) begin
					bad = 1'b1;
				end else begin
					unique case (n_phase)
						hhbp_pkg::PH_NAME: begin
							do_name = 1'b1;
						end
						hhbp_pkg::PH_NAME_CR: begin
							if (b == hhbp_pkg::CH_LF) begin
								if (n_line == 17'd2) begin
									done = 1'b1;
								end else begin
									bad = 1'b1;
								end
							end else begin
								n_phase = hhbp_pkg::PH_NAME;
								do_name = 1'b1;
							end
						end
						hhbp_pkg::PH_SP1: begin
							if (b != hhbp_pkg::CH_SPACE) begin
								n_phase = hhbp_pkg::PH_VAL;
								do_val  = 1'b1;
							end
						end
						hhbp_pkg::PH_VAL: begin
							do_val = 1'b1;
						end
						hhbp_pkg::PH_VAL_CR: begin
							if (b == hhbp_pkg::CH_LF) begin
								do_end = 1'b1;
							end else begin
								// The lone CR was a value byte after all
								if (n_vlen == 2'd0) begin
									n_vzero = 1'b0;
								end
								if (n_vlen != 2'd3) begin
									n_vlen = n_vlen + 2'd1;
								end
								if (n_mconn) begin
									if (!sv) begin
										sv = 1'b1;
										sb = hhbp_pkg::CH_CR;
									end else begin
										n_hold_v = 1'b1;
										n_hold_b = hhbp_pkg::CH_CR;
									end
								end
								n_phase = hhbp_pkg::PH_VAL;
								do_val  = 1'b1;
							end
						end
						hhbp_pkg::PH_SP2: begin
							if (b == hhbp_pkg::CH_CR) begin
								n_phase = hhbp_pkg::PH_SP2_CR;
							end else if (b != hhbp_pkg::CH_SPACE) begin
								bad = 1'b1;
							end
						end
						hhbp_pkg::PH_SP2_CR: begin
							if (b == hhbp_pkg::CH_LF) begin
								do_end = 1'b1;
							end else begin
								bad = 1'b1;
							end
						end
						default: begin
							bad = 1'b1;
						end
					endcase
				end

				// Header name byte
				if (do_name) begin
					if (b == hhbp_pkg::CH_COLON) begin
						is_c = n_mconn && (n_npos == hhbp_pkg::CONN_NAME_LEN);
						is_l = n_mclen && (n_npos == hhbp_pkg::CLEN_NAME_LEN);
						if (n_npos == 4'd0) begin
							bad = 1'b1;
						end else if ((is_c && n_cflag) || (is_l && n_lflag)) begin
							bad = 1'b1;
						end else begin
							n_mconn = is_c;
							n_mclen = is_l;
							n_phase = hhbp_pkg::PH_SP1;
						end
					end else if (b == hhbp_pkg::CH_SPACE) begin
						bad = 1'b1;
					end else begin
						if ((n_npos >= hhbp_pkg::CONN_NAME_LEN) ||
						    (lcb != hhbp_pkg::conn_char(n_npos))) begin
							n_mconn = 1'b0;
						end
						if ((n_npos >= hhbp_pkg::CLEN_NAME_LEN) ||
						    (lcb != hhbp_pkg::clen_char(n_npos))) begin
							n_mclen = 1'b0;
						end
						if (n_npos != 4'd15) begin
							n_npos = n_npos + 4'd1;
						end
						if (b == hhbp_pkg::CH_CR) begin
							n_phase = hhbp_pkg::PH_NAME_CR;
						end
					end
				end

				// Header value byte
				if (do_val) begin
					if (b == hhbp_pkg::CH_SPACE) begin
						n_phase = hhbp_pkg::PH_SP2;
					end else if (b == hhbp_pkg::CH_CR) begin
						n_phase = hhbp_pkg::PH_VAL_CR;
					end else begin
						if (n_vlen == 2'd0) begin
							n_vzero = (b == hhbp_pkg::CH_ZERO);
						end
						if (n_vlen != 2'd3) begin
							n_vlen = n_vlen + 2'd1;
						end
						if (n_mconn) begin
							if (!sv) begin
								sv = 1'b1;
								sb = b;
							end else begin
								n_hold_v = 1'b1;
								n_hold_b = b;
							end
						end
					end
				end

				// Close a header line and check the known headers
				if (do_end) begin
					if (n_mconn) begin
						if (n_vlen == 2'd0) begin
							bad = 1'b1;
						end else begin
							n_cflag = 1'b1;
						end
					end else if (n_mclen) begin
						if (!((n_vlen == 2'd1) && n_vzero)) begin
							bad = 1'b1;
						end else begin
							n_lflag = 1'b1;
						end
					end
					if (!bad) begin
						n_phase = hhbp_pkg::PH_NAME;
						n_line  = '0;
						n_npos  = '0;
						n_mconn = 1'b1;
						n_mclen = 1'b1;
						n_vlen  = '0;
						n_vzero = 1'b0;
					end
				end

				if (bad) begin
					n_fin    = 1'b1;
					n_hold_v = 1'b0;
					st       = hhbp_pkg::ST_BAD;
				end else if (done) begin
					n_fin = 1'b1;
					st    = hhbp_pkg::ST_DONE;
				end
			end
		end

		// Drop value output on any terminal result
		if (st != hhbp_pkg::ST_BUSY) begin
			sv = 1'b0;
			sb = 8'h00;
		end

		res.status           = st;
		res.conn_value_valid = sv;
		res.conn_value_byte  = sb;
		res.conn_seen        = n_cflag;
		res.clen_seen        = n_lflag;
	end

	// Advance parser state as each byte is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= hhbp_pkg::PH_NAME;
			line_q   <= '0;
			npos_q   <= '0;
			mconn_q  <= 1'b1;
			mclen_q  <= 1'b1;
			cflag_q  <= 1'b0;
			lflag_q  <= 1'b0;
			vlen_q   <= '0;
			vzero_q  <= 1'b0;
			fin_q    <= 1'b0;
			hold_v_q <= 1'b0;
			hold_b_q <= 8'h00;
		end else if (fire_s1) begin
			phase_q  <= n_phase;
			line_q   <= n_line;
			npos_q   <= n_npos;
			mconn_q  <= n_mconn;
			mclen_q  <= n_mclen;
			cflag_q  <= n_cflag;
			lflag_q  <= n_lflag;
			vlen_q   <= n_vlen;
			vzero_q  <= n_vzero;
			fin_q    <= n_fin;
			hold_v_q <= n_hold_v;
			hold_b_q <= n_hold_b;
		end
	end

	// Hold the result until the output transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fire_s1) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_q <= res;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/hhbp_checker.sv
// Port-level checker for the HTTP header block parser, bound to the top level.
`default_nettype none
module hhbp_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  in_ready,
	input wire                  out_valid,
	input wire                  out_ready,
	input hhbp_pkg::out_item_t  out_data
);

	// A stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Value bytes only appear while the block is still in progress
	a_value_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.conn_value_valid |->
			out_data.status == hhbp_pkg::ST_BUSY)
		else $error("value byte with terminal status");

	// An idle value slot carries a zero byte
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.conn_value_valid |-> out_data.conn_value_byte == 8'h00)
		else $error("stray value byte");

	// With the result register empty, input is never stalled
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!out_valid) && !out_valid |-> in_ready)
		else $error("input stalled with empty pipeline");

endmodule

bind http_header_block_parser hhbp_checker u_hhbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

// File: bench/http_header_block_parser_tb.sv
// Self-checking testbench for the HTTP header block parser: predicted results, random traffic.
`default_nettype none
module http_header_block_parser_tb;

	localparam int IDLE_PCT = 34;
	localparam int PRINT_CAP = 50;
	localparam int PHASE_ITEMS = 220;
	localparam logic [15:0] LONG_LIMIT = 16'd160;
	localparam logic [8*10-1:0] CONN_WORD = "connection";
	localparam logic [8*14-1:0] CLEN_WORD = "content-length";

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	hhbp_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready = 1'b0;
	hhbp_pkg::out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [15:0] cfg_data;

	// Parser model state
	logic [15:0] line_limit;
	hhbp_pkg::phase_t ph;
	logic [16:0] lcount;
	logic [3:0] npos;
	bit m_conn;
	bit m_clen;
	bit conn_f;
	bit clen_f;
	logic [1:0] vlen;
	bit vzero;
	bit done_f;
	bit hold_v;
	logic [7:0] hold_b;
	bit slot_v;
	logic [7:0] slot_b;

	hhbp_pkg::out_item_t results_due[$];
	hhbp_pkg::out_item_t due_r;
	logic [7:0] block_bytes[$];
	int mismatch_count = 0;
	int results_seen = 0;
	int sent_items = 0;
	bit calm = 1'b0;

	http_header_block_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- model

	function automatic void restart_line();
		ph = hhbp_pkg::PH_NAME;
		lcount = '0;
		npos = '0;
		m_conn = 1'b1;
		m_clen = 1'b1;
		vlen = '0;
		vzero = 1'b0;
	endfunction

	function automatic void clear_block();
		restart_line();
		conn_f = 1'b0;
		clen_f = 1'b0;
		done_f = 1'b0;
		hold_v = 1'b0;
		hold_b = '0;
	endfunction

	function automatic hhbp_pkg::status_t reject();
		done_f = 1'b1;
		hold_v = 1'b0;
		return hhbp_pkg::ST_BAD;
	endfunction

	// Confirm one value byte; connection bytes go out now or one step late
	function automatic void take_value_byte(input logic [7:0] b);
		if (vlen == 2'd0)
			vzero = (b == hhbp_pkg::CH_ZERO);
		if (vlen != 2'd3)
			vlen++;
		if (m_conn) begin
			if (!slot_v) begin
				slot_v = 1'b1;
				slot_b = b;
			end else begin
				hold_v = 1'b1;
				hold_b = b;
			end
		end
	endfunction

	function automatic hhbp_pkg::status_t close_line();
		if (m_conn) begin
			if (vlen == 2'd0)
				return reject();
			conn_f = 1'b1;
		end else if (m_clen) begin
			if (!(vlen == 2'd1 && vzero))
				return reject();
			clen_f = 1'b1;
		end
		restart_line();
		return hhbp_pkg::ST_BUSY;
	endfunction

	function automatic hhbp_pkg::status_t name_char(input logic [7:0] b);
		logic [7:0] lc;
		bit is_c;
		bit is_l;
		if (b == hhbp_pkg::CH_COLON) begin
			if (npos == 4'd0)
				return reject();
			is_c = m_conn && npos == hhbp_pkg::CONN_NAME_LEN;
			is_l = m_clen && npos == hhbp_pkg::CLEN_NAME_LEN;
			if ((is_c && conn_f) || (is_l && clen_f))
				return reject();
			m_conn = is_c;
			m_clen = is_l;
			ph = hhbp_pkg::PH_SP1;
			return hhbp_pkg::ST_BUSY;
		end
		if (b == hhbp_pkg::CH_SPACE)
			return reject();
		lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
		if (npos >= hhbp_pkg::CONN_NAME_LEN)
			m_conn = 1'b0;
		else if (lc != CONN_WORD[8*(9-int'(npos)) +: 8])
			m_conn = 1'b0;
		if (npos >= hhbp_pkg::CLEN_NAME_LEN)
			m_clen = 1'b0;
		else if (lc != CLEN_WORD[8*(13-int'(npos)) +: 8])
			m_clen = 1'b0;
		if (npos != 4'd15)
			npos++;
		if (b == hhbp_pkg::CH_CR)
			ph = hhbp_pkg::PH_NAME_CR;
		return hhbp_pkg::ST_BUSY;
	endfunction

	function automatic hhbp_pkg::status_t value_char(input logic [7:0] b);
		if (b == hhbp_pkg::CH_SPACE) begin
			ph = hhbp_pkg::PH_SP2;
			return hhbp_pkg::ST_BUSY;
		end
		if (b == hhbp_pkg::CH_CR) begin
			ph = hhbp_pkg::PH_VAL_CR;
			return hhbp_pkg::ST_BUSY;
		end
		take_value_byte(b);
		return hhbp_pkg::ST_BUSY;
	endfunction

	function automatic hhbp_pkg::status_t parse_byte(input logic [7:0] b);
		if (lcount != hhbp_pkg::LINE_COUNT_MAX)
			lcount++;
		if (lcount > {1'b0, line_limit})
			return reject();
		case (ph)
			hhbp_pkg::PH_NAME: return name_char(b);
			hhbp_pkg::PH_NAME_CR: begin
				if (b == hhbp_pkg::CH_LF) begin
					if (lcount == 17'd2) begin
						done_f = 1'b1;
						return hhbp_pkg::ST_DONE;
					end
					return reject();
				end
				ph = hhbp_pkg::PH_NAME;
				return name_char(b);
			end
			hhbp_pkg::PH_SP1: begin
				if (b == hhbp_pkg::CH_SPACE)
					return hhbp_pkg::ST_BUSY;
				ph = hhbp_pkg::PH_VAL;
				return value_char(b);
			end
			hhbp_pkg::PH_VAL: return value_char(b);
			hhbp_pkg::PH_VAL_CR: begin
				if (b == hhbp_pkg::CH_LF)
					return close_line();
				// lone CR belongs to the value
				take_value_byte(hhbp_pkg::CH_CR);
				ph = hhbp_pkg::PH_VAL;
				return value_char(b);
			end
			hhbp_pkg::PH_SP2: begin
				if (b == hhbp_pkg::CH_SPACE)
					return hhbp_pkg::ST_BUSY;
				if (b == hhbp_pkg::CH_CR) begin
					ph = hhbp_pkg::PH_SP2_CR;
					return hhbp_pkg::ST_BUSY;
				end
				return reject();
			end
			hhbp_pkg::PH_SP2_CR: begin
				if (b == hhbp_pkg::CH_LF)
					return close_line();
				return reject();
			end
			default: return reject();
		endcase
	endfunction

	// Advance the model by one transaction and return the result it produces
	function automatic hhbp_pkg::out_item_t parser_step(input hhbp_pkg::in_item_t it);
		hhbp_pkg::status_t st;
		hhbp_pkg::out_item_t r;
		if (it.first)
			clear_block();
		slot_v = 1'b0;
		slot_b = '0;
		if (done_f) begin
			st = hhbp_pkg::ST_IGNORED;
		end else begin
			if (hold_v) begin
				slot_v = 1'b1;
				slot_b = hold_b;
				hold_v = 1'b0;
			end
			if (it.cmd) begin
				done_f = 1'b1;
				hold_v = 1'b0;
				st = hhbp_pkg::ST_CLOSED;
			end else begin
				st = parse_byte(it.data_byte);
			end
		end
		if (st != hhbp_pkg::ST_BUSY) begin
			slot_v = 1'b0;
			slot_b = '0;
		end
		r.status = st;
		r.conn_value_valid = slot_v;
		r.conn_value_byte = slot_v ? slot_b : 8'd0;
		r.conn_seen = conn_f;
		r.clen_seen = clen_f;
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what);
		if (mismatch_count < PRINT_CAP)
			$display("MISMATCH result %0d at %0t: %s", results_seen, $time, what);
		mismatch_count++;
	endtask

	task automatic check_field(input string field, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
	endtask

	// Compare each result transaction with the oldest pending prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				report_mismatch("result with no transaction pending");
			end else begin
				due_r = results_due.pop_front();
				check_field("status", 8'(out_data.status), 8'(due_r.status));
				check_field("conn_value_valid", 8'(out_data.conn_value_valid),
					8'(due_r.conn_value_valid));
				check_field("conn_value_byte", out_data.conn_value_byte,
					due_r.conn_value_byte);
				check_field("conn_seen", 8'(out_data.conn_seen), 8'(due_r.conn_seen));
				check_field("clen_seen", 8'(out_data.clen_seen), 8'(due_r.clen_seen));
			end
			results_seen++;
		end
	end

	// Stall the result side at random, except in calm stretches
	always @(posedge clk)
		out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

	// ---------------------------------------------------------------- stimulus

	task automatic send_item(input bit c, input logic [7:0] b, input bit f);
		hhbp_pkg::in_item_t it;
		it.cmd = c;
		it.data_byte = b;
		it.first = f;
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		results_due.push_back(parser_step(it));
		sent_items++;
	endtask

	// Send the built block; the first byte restarts the parser, close_at swaps in a peer close
	task automatic send_block(input int close_at);
		for (int i = 0; i < block_bytes.size(); i++) begin
			if (i == close_at) begin
				send_item(1'b1, 8'($urandom_range(0, 255)), i == 0);
				break;
			end
			send_item(1'b0, block_bytes[i], i == 0);
		end
	endtask

	// Hold input, wait for every pending result, then let the pipeline settle
	task automatic drain(input int settle);
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_line_limit(input logic [15:0] v);
		drain(4);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		line_limit = v;
	endtask

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			block_bytes.push_back(s[i]);
	endfunction

	function automatic void add_crlf();
		block_bytes.push_back(hhbp_pkg::CH_CR);
		block_bytes.push_back(hhbp_pkg::CH_LF);
	endfunction

	function automatic void add_mixed_case(input string s);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
				c = c - 8'd32;
			block_bytes.push_back(c);
		end
	endfunction

	// Value token of arbitrary bytes, now and then with a lone CR inside
	function automatic void add_token();
		logic [7:0] b;
		repeat ($urandom_range(1, 5)) begin
			if ($urandom_range(0, 9) == 0) begin
				block_bytes.push_back(hhbp_pkg::CH_CR);
				do b = 8'($urandom_range(0, 255)); while (b == hhbp_pkg::CH_LF);
			end else begin
				do b = 8'($urandom_range(0, 255));
				while (b == hhbp_pkg::CH_SPACE || b == hhbp_pkg::CH_CR);
			end
			block_bytes.push_back(b);
		end
	endfunction

	// ---------------------------------------------------------------- tests

	// Connection header with an extreme byte, then ignored bytes and a peer close
	task automatic test_basic_block();
		block_bytes.delete();
		add_text("Connection:");
		block_bytes.push_back(8'hFF);
		add_crlf();
		add_crlf();
		send_block(-1);
		send_item(1'b0, 8'h00, 1'b0);
		send_item(1'b1, 8'h55, 1'b1);
		send_item(1'b0, 8'hAA, 1'b0);
	endtask

	// Line exactly at a configured limit, then one byte over it
	task automatic test_long_line();
		set_line_limit(LONG_LIMIT);
		calm = 1'b1;
		block_bytes.delete();
		add_text("x:");
		repeat (int'(LONG_LIMIT) - 4) block_bytes.push_back("a");
		add_crlf();
		add_crlf();
		send_block(-1);
		block_bytes.delete();
		repeat (int'(LONG_LIMIT) + 1) block_bytes.push_back("a");
		send_block(-1);
		calm = 1'b0;
	endtask

	// Lines at and just past small limits, the smallest among them
	task automatic test_line_limit();
		set_line_limit(16'd5);
		block_bytes.delete();
		add_text("a:b");
		add_crlf();
		add_crlf();
		send_block(-1);
		block_bytes.delete();
		add_text("ab:c");
		add_crlf();
		send_block(-1);
		set_line_limit(16'd3);
		block_bytes.delete();
		add_crlf();
		send_block(-1);
		block_bytes.delete();
		add_text("a:b");
		add_crlf();
		send_block(-1);
	endtask

	// One random header block, mostly well formed, plus trailing bytes and noise
	task automatic random_round();
		int kind;
		int close_at;
		int pos;
		logic [7:0] b;
		block_bytes.delete();
		close_at = -1;
		repeat ($urandom_range(0, 4)) begin
			kind = $urandom_range(0, 9);
			if (kind == 9) begin
				case ($urandom_range(0, 3))
					0: add_text(":x");
					1: add_text("a b:x");
					2: add_text("x: a b");
					default: add_text("abc");
				endcase
			end else begin
				case (kind)
					0, 1, 2: add_mixed_case("connection");
					3, 4: add_mixed_case("content-length");
					8: begin
						if ($urandom_range(0, 1) == 0)
							add_mixed_case("connections");
						else
							add_mixed_case("content-lengt");
					end
					default: begin
						repeat ($urandom_range(1, 6)) begin
							do b = 8'($urandom_range(0, 255));
							while (b == hhbp_pkg::CH_COLON || b == hhbp_pkg::CH_SPACE ||
								b == hhbp_pkg::CH_CR);
							block_bytes.push_back(b);
						end
						if ($urandom_range(0, 7) == 0) begin
							block_bytes.push_back(hhbp_pkg::CH_CR);
							block_bytes.push_back("x");
						end
					end
				endcase
				block_bytes.push_back(hhbp_pkg::CH_COLON);
				repeat ($urandom_range(0, 2)) block_bytes.push_back(hhbp_pkg::CH_SPACE);
				if (kind == 3 || kind == 4) begin
					case ($urandom_range(0, 6))
						4: add_text("00");
						5: block_bytes.push_back(hhbp_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
						6: ;
						default: add_text("0");
					endcase
				end else if ($urandom_range(0, 11) != 0) begin
					add_token();
				end
				repeat ($urandom_range(0, 2)) block_bytes.push_back(hhbp_pkg::CH_SPACE);
			end
			add_crlf();
		end
		add_crlf();

		// Break some blocks: corrupt, insert a space, drop, close early, cut short
		pos = $urandom_range(0, block_bytes.size() - 1);
		case ($urandom_range(0, 15))
			0: block_bytes[pos] = 8'($urandom_range(0, 255));
			1: block_bytes.insert(pos, hhbp_pkg::CH_SPACE);
			2: block_bytes.delete(pos);
			3: close_at = pos;
			4: block_bytes = block_bytes[0:pos];
			default: ;
		endcase
		send_block(close_at);

		repeat ($urandom_range(0, 2))
			send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 6))
				send_item($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)),
					$urandom_range(0, 3) == 0);
		end
	endtask

	// Random blocks under several limits; one phase runs without any idling
	task automatic test_random_traffic();
		logic [15:0] limit_plan [0:4];
		int target;
		limit_plan[0] = 16'd65535;
		limit_plan[1] = 16'd3;
		limit_plan[2] = 16'd12;
		limit_plan[3] = 16'd40;
		limit_plan[4] = 16'($urandom_range(3, 65535));
		for (int p = 0; p < 5; p++) begin
			set_line_limit(limit_plan[p]);
			calm = (p == 3);
			target = sent_items + PHASE_ITEMS;
			while (sent_items < target)
				random_round();
			calm = 1'b0;
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		line_limit = hhbp_pkg::LINE_LIMIT_RESET;
		clear_block();
		slot_v = 1'b0;
		slot_b = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_block();
		test_long_line();
		test_line_limit();
		test_random_traffic();

		drain(8);
		if (mismatch_count == 0 && results_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Stop a hung run
	initial begin
		#5000000;
		$display("timeout with %0d results pending", results_due.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire
